// ===== rtl/core/rfid_serial_frame_parser_top_assert.svh =====
// Assertion macros for the tag frame parser checker.
// RFSP_ASSERT checks a property while reset is released.
// RFSP_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef RFID_SERIAL_FRAME_PARSER_TOP_ASSERT_SVH
`define RFID_SERIAL_FRAME_PARSER_TOP_ASSERT_SVH

`define RFSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("tag frame parser check failed");

`define RFSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tag frame parser check failed");

`endif

// ===== rtl/core/rfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsp_pkg
// Types, codes and the hex digit decoder shared by the tag frame parser.
// ----------------------------------------------------------------------------
package rfsp_pkg;

    localparam int TagBits   = 32;
    localparam int ByteBits  = 8;
    localparam int CountBits = 4;
    localparam int DigitBits = 4;

    typedef logic [TagBits-1:0]   tag_t;
    typedef logic [ByteBits-1:0]  byte_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [DigitBits-1:0] digit_t;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_NEW     = 2'd0;
    localparam status_t ST_REPEAT  = 2'd1;
    localparam status_t ST_BAD_END = 2'd2;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_START_MARKER = 2'd0;
    localparam cfg_index_t REG_END_MARKER   = 2'd1;
    localparam cfg_index_t REG_SKIP_BEFORE  = 2'd2;
    localparam cfg_index_t REG_SKIP_AFTER   = 2'd3;

    // Reset values
    localparam byte_t  START_MARKER_RST = 8'h02;
    localparam byte_t  END_MARKER_RST   = 8'h03;
    localparam count_t SKIP_BEFORE_RST  = 4'd2;
    localparam count_t SKIP_AFTER_RST   = 4'd2;
    localparam tag_t   TAG_ALL_ONES     = 32'hFFFF_FFFF;

    typedef struct packed {
        byte_t  start_marker;
        byte_t  end_marker;
        count_t skip_before;
        count_t skip_after;
    } cfg_t;

    typedef struct packed {
        logic    valid;
        status_t status;
        tag_t    tag;
    } result_t;

    typedef struct packed {
        logic   is_hex;
        digit_t value;
    } hex_digit_t;

    // Decode one ASCII hex character: 0-9, A-F, a-f
    function automatic hex_digit_t hex_decode(input byte_t c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.is_hex = 1'b1;
            d.value  = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.is_hex = 1'b1;
            d.value  = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/rfsp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rfsp_cfg_regs
// Configuration registers of the tag frame parser, written over a
// valid/ready channel that never stalls.
// ----------------------------------------------------------------------------
module rfsp_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rfsp_pkg::cfg_index_t cfg_index,
    input  rfsp_pkg::byte_t     cfg_data,
    output rfsp_pkg::cfg_t      cfg
);

    rfsp_pkg::cfg_t cfg_reg;
    rfsp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                rfsp_pkg::REG_START_MARKER: cfg_next.start_marker = cfg_data;
                rfsp_pkg::REG_END_MARKER:   cfg_next.end_marker   = cfg_data;
                rfsp_pkg::REG_SKIP_BEFORE:  cfg_next.skip_before  = cfg_data[3:0];
                rfsp_pkg::REG_SKIP_AFTER:   cfg_next.skip_after   = cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= rfsp_pkg::START_MARKER_RST;
            cfg_reg.end_marker   <= rfsp_pkg::END_MARKER_RST;
            cfg_reg.skip_before  <= rfsp_pkg::SKIP_BEFORE_RST;
            cfg_reg.skip_after   <= rfsp_pkg::SKIP_AFTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/rfsp_frame_core.sv =====
// ----------------------------------------------------------------------------
// rfsp_frame_core
// Frame state machine: start marker, leading skip, hex digit collection,
// trailing skip and end marker check. Advances one byte per step.
// ----------------------------------------------------------------------------
module rfsp_frame_core #(
    parameter int TAG_DIGITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  rfsp_pkg::byte_t   rx_byte,
    input  rfsp_pkg::cfg_t    cfg,
    output rfsp_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_WAIT_START,
        PH_SKIP_BEFORE,
        PH_DIGITS,
        PH_SKIP_AFTER,
        PH_WAIT_END
    } phase_t;

    localparam int LenBits = rfsp_pkg::CountBits + 1;
    localparam logic [LenBits-1:0] DigitsLen = LenBits'(TAG_DIGITS);

    phase_t                phase_reg,    phase_next;
    rfsp_pkg::count_t      count_reg,    count_next;
    rfsp_pkg::tag_t        acc_reg,      acc_next;
    logic                  ovf_reg,      ovf_next;
    logic                  stopped_reg,  stopped_next;
    rfsp_pkg::tag_t        last_tag_reg, last_tag_next;

    rfsp_pkg::hex_digit_t  digit;
    logic [LenBits-1:0]    count_plus;
    rfsp_pkg::tag_t        frame_tag;

    assign digit      = rfsp_pkg::hex_decode(rx_byte);
    assign count_plus = {1'b0, count_reg} + LenBits'(1);
    assign frame_tag  = ovf_reg ? rfsp_pkg::TAG_ALL_ONES : acc_reg;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        stopped_next  = stopped_reg;
        last_tag_next = last_tag_reg;
        result        = '0;
        unique case (phase_reg)
            PH_SKIP_BEFORE: begin
                if (count_plus >= {1'b0, cfg.skip_before}) begin
                    count_next = '0;
                    phase_next = PH_DIGITS;
                end else begin
                    count_next = count_plus[rfsp_pkg::CountBits-1:0];
                end
            end
            PH_DIGITS: begin
                if (!stopped_reg) begin
                    if (!digit.is_hex) begin
                        stopped_next = 1'b1;
                    end else begin
                        // Flag any digits shifted off the top
                        if (acc_reg[rfsp_pkg::TagBits-1 -: rfsp_pkg::DigitBits] != '0) begin
                            ovf_next = 1'b1;
                        end
                        acc_next = {acc_reg[rfsp_pkg::TagBits-rfsp_pkg::DigitBits-1:0],
                                    digit.value};
                    end
                end
                if (count_plus >= DigitsLen) begin
                    count_next = '0;
                    phase_next = PH_SKIP_AFTER;
                end else begin
                    count_next = count_plus[rfsp_pkg::CountBits-1:0];
                end
            end
            PH_SKIP_AFTER: begin
                if (count_plus >= {1'b0, cfg.skip_after}) begin
                    count_next = '0;
                    phase_next = PH_WAIT_END;
                end else begin
                    count_next = count_plus[rfsp_pkg::CountBits-1:0];
                end
            end
            PH_WAIT_END: begin
                result.valid = 1'b1;
                if (rx_byte == cfg.end_marker) begin
                    result.tag    = frame_tag;
                    result.status = (frame_tag != last_tag_reg) ? rfsp_pkg::ST_NEW
                                                                : rfsp_pkg::ST_REPEAT;
                    last_tag_next = frame_tag;
                end else begin
                    result.status = rfsp_pkg::ST_BAD_END;
                end
                count_next = '0;
                phase_next = PH_WAIT_START;
            end
            default: begin
                // Waiting for start; unused codes land here too
                phase_next = PH_WAIT_START;
                if (rx_byte == cfg.start_marker) begin
                    count_next   = '0;
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    stopped_next = 1'b0;
                    phase_next   = PH_SKIP_BEFORE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT_START;
            count_reg    <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            stopped_reg  <= 1'b0;
            last_tag_reg <= rfsp_pkg::TAG_ALL_ONES;
        end else if (step) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            stopped_reg  <= stopped_next;
            last_tag_reg <= last_tag_next;
        end
    end

endmodule

// ===== rtl/core/rfid_serial_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// rfid_serial_frame_parser_top
// Parses framed ASCII hex tag numbers from a serial tag reader byte stream.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Direction  Carries
//  -------  -----------------------------  ---------  -------------------------
//  s_       s_valid s_ready s_rx_byte      in         one received byte
//  m_       m_valid m_ready m_frame_status out        frame result and tag
//           m_tag_value
//  cfg_     cfg_valid cfg_ready cfg_index  in         register index and data
//           cfg_data
//
//  One item per cycle sustained while results are accepted; an item passes an
//  input register, the frame state machine and a result register.
//  The frame state advances once per item.
//  Reset (aresetn low, synchronous) empties both registers, returns the
//  parser to waiting for a start marker and sets the last tag to all ones.
//  A stalled result holds only items that give a result; bytes inside a
//  frame keep flowing while the result register waits.
//  The configuration channel is always ready and takes effect on the next
//  item.
//
module rfid_serial_frame_parser_top #(
    parameter int TAG_DIGITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_frame_status,
    output logic [31:0]           m_tag_value,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    // Input register
    logic                    in_valid_reg, in_valid_next;
    rfsp_pkg::byte_t         in_byte_reg,  in_byte_next;

    // Result register
    logic                    out_valid_reg,  out_valid_next;
    rfsp_pkg::status_t       out_status_reg, out_status_next;
    rfsp_pkg::tag_t          out_tag_reg,    out_tag_next;

    rfsp_pkg::cfg_t          cfg;
    rfsp_pkg::result_t       result;
    logic                    step;

    rfsp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfsp_frame_core #(
        .TAG_DIGITS (TAG_DIGITS)
    ) u_frame_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Advance the held item unless it makes a result that has nowhere to go
    assign step    = in_valid_reg && (!result.valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        if (step && result.valid) begin
            out_valid_next  = 1'b1;
            out_status_next = result.status;
            out_tag_next    = result.tag;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_status = out_status_reg;
    assign m_tag_value    = out_tag_reg;

endmodule

// ===== rtl/core/rfsp_checker.sv =====
// ----------------------------------------------------------------------------
// rfsp_checker
// Port-level checks of the tag frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "rfid_serial_frame_parser_top_assert.svh"

module rfsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_frame_status,
    input logic [31:0] m_tag_value,
    input logic        cfg_ready
);

    logic        m_stalled;
    logic        bad_end;
    logic [33:0] result_word;

    assign m_stalled   = m_valid && !m_ready;
    assign bad_end     = m_valid && (m_frame_status == rfsp_pkg::ST_BAD_END);
    assign result_word = {m_frame_status, m_tag_value};

    // A stalled result holds
    `RFSP_ASSERT(a_result_held, aclk, aresetn, m_stalled |=> m_valid && $stable(result_word))

    // Status stays within its three codes
    `RFSP_ASSERT(a_status_code, aclk, aresetn, m_valid |-> m_frame_status <= rfsp_pkg::ST_BAD_END)

    // A bad end marker carries a zero tag
    `RFSP_ASSERT(a_bad_end_zero, aclk, aresetn, bad_end |-> m_tag_value == '0)

    // Reset empties the block: no result and ready for input
    `RFSP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready && cfg_ready)

endmodule

bind rfid_serial_frame_parser_top rfsp_checker u_rfsp_checker (.*);
